// ===== rtl/hex_payload_key_value_extractor_core_macros.svh =====
// Assertion macros shared by the files of the hex payload key/value extractor.
`ifndef HEX_PAYLOAD_KEY_VALUE_EXTRACTOR_CORE_MACROS_SVH
`define HEX_PAYLOAD_KEY_VALUE_EXTRACTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition in one cycle implies a consequence in the same cycle.
`define HPKV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpkv assertion failed");
// Condition in one cycle implies a consequence in the next cycle.
`define HPKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpkv assertion failed");
`else
`define HPKV_ASSERT_SAME(label, ante, cons)
`define HPKV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/hpkv_pkg.sv =====
// Types, constants and key table of the hex payload key/value extractor.
package hpkv_pkg;

  // Input beat: one hex character and the end-of-payload flag.
  typedef struct packed {
    logic [7:0] hex_char;
    logic       last;
  } hpkv_in_t;

  // Result beat: parsed value and the found flag.
  typedef struct packed {
    logic signed [31:0] value;
    logic               found;
  } hpkv_out_t;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_SPACE  = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } hpkv_phase_t;

  localparam logic [3:0]  KEY_LEN    = 4'd8;
  localparam logic [35:0] MAG_LIMIT  = 36'h0_8000_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] NOT_FOUND  = 32'hFFFF_FFFF;

  // Key text: quote, v, a, l, u, e, quote, colon.
  function automatic logic [7:0] key_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h22;
      3'd1:    b = 8'h76;
      3'd2:    b = 8'h61;
      3'd3:    b = 8'h6C;
      3'd4:    b = 8'h75;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h22;
      default: b = 8'h3A;
    endcase
    return b;
  endfunction

  // Fallback position after a mismatch; only the colon position falls back
  // to the state where a quote has already been matched.
  function automatic logic [2:0] key_fallback(input logic [2:0] idx);
    return (idx == 3'd7) ? 3'd1 : 3'd0;
  endfunction

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the nibble.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'b0_0000;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hex_payload_key_value_extractor_core.sv =====
// Top level of the hex payload key/value extractor: beat registers and handshakes.
//
//  channel  | handshake            | payload               | beats
//  ---------+----------------------+-----------------------+------------------------
//  in_      | in_valid / in_stall  | hpkv_in_t  in_data    | one hex character each
//  out_     | out_valid / out_stall| hpkv_out_t out_data   | one per beat with last
//
// One beat is accepted per cycle while in_stall is low. A beat is registered in the input
// register; when it moves on, the parser updates its state and a last beat loads the
// result register, which then drives the result with out_valid.
// Reset is synchronous on rst_n low and returns the parser to a fresh payload.
// out_stall holds back only a last beat while the result register is still
// full; other beats keep flowing.
module hex_payload_key_value_extractor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hpkv_pkg::hpkv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hpkv_pkg::hpkv_out_t out_data
);
  import hpkv_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  hpkv_in_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  hpkv_out_t out_r;
  hpkv_out_t result;
  logic      out_free;
  logic      adv;

  // A beat in the input register moves on unless it is a last beat that
  // finds the result register occupied.
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && (!in_r.last || out_free);
  assign in_stall = in_vld_r && !adv;

  assign in_vld_nxt  = in_stall ? 1'b1 : in_valid;
  assign out_vld_nxt = (adv && in_r.last) ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  hpkv_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .beat   (in_r),
    .result (result)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
    if (adv && in_r.last) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`include "hex_payload_key_value_extractor_core_macros.svh"

  // A last beat that moves on always produces a result in the next cycle.
  `HPKV_ASSERT_NEXT(a_last_gives_result, adv && in_r.last, out_vld_r)
  // A result without a found number carries minus one.
  `HPKV_ASSERT_SAME(a_not_found_value, out_vld_r && !out_data.found, out_data.value == NOT_FOUND)
  // A blocked last beat stays in the input register.
  `HPKV_ASSERT_NEXT(a_last_held, in_vld_r && in_r.last && out_vld_r && out_stall, in_vld_r && in_r.last)
  // The parser never advances a last beat onto an undrained result.
  `HPKV_ASSERT_SAME(a_no_overwrite, adv && in_r.last && out_vld_r, !out_stall)

endmodule

// ===== rtl/hpkv_parser.sv =====
// Byte assembly, key search and number parser with its per-payload state.
module hpkv_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hpkv_pkg::hpkv_in_t  beat,
  output hpkv_pkg::hpkv_out_t result
);
  import hpkv_pkg::*;

  logic        nphase_r, nphase_nxt;
  logic [3:0]  high_r, high_nxt;
  logic        stopped_r, stopped_nxt;
  logic [3:0]  kcnt_r, kcnt_nxt;
  hpkv_phase_t phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        digit_r, digit_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic [4:0]  nib;
  logic [7:0]  byte_w;
  logic        take;
  logic        is_digit;
  logic        is_space;
  logic [2:0]  k0, k1, k2;
  logic [3:0]  kn;
  logic [35:0] acc_wide;

  // Character decode and candidate byte.
  assign nib      = hex_nibble(beat.hex_char);
  assign byte_w   = {high_r, nib[3:0]};
  assign is_digit = (byte_w >= 8'h30) && (byte_w <= 8'h39);
  assign is_space = (byte_w == 8'h20) || ((byte_w >= 8'h09) && (byte_w <= 8'h0D));

  // Key match with fallback: at most two fallback steps are ever needed.
  always_comb begin
    k0 = kcnt_r[3] ? 3'd0 : kcnt_r[2:0];
    k1 = ((k0 != 3'd0) && (byte_w != key_byte(k0))) ? key_fallback(k0) : k0;
    k2 = ((k1 != 3'd0) && (byte_w != key_byte(k1))) ? key_fallback(k1) : k1;
    kn = {1'b0, k2} + {3'b000, (byte_w == key_byte(k2))};
  end

  // Magnitude times ten plus the new digit, saturated at the limit.
  always_comb begin
    acc_wide = ({4'b0000, acc_r} << 3) + ({4'b0000, acc_r} << 1)
             + {32'd0, byte_w[3:0]};
    if (acc_wide > MAG_LIMIT) begin
      acc_wide = MAG_LIMIT;
    end
  end

  // Next state for one beat, result from the updated state, then the
  // payload-end clear.
  always_comb begin
    nphase_nxt  = nphase_r;
    high_nxt    = high_r;
    stopped_nxt = stopped_r;
    kcnt_nxt    = kcnt_r;
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    digit_nxt   = digit_r;
    acc_nxt     = acc_r;
    take        = 1'b0;

    if (!stopped_r) begin
      if (!nib[4]) begin
        stopped_nxt = 1'b1;
      end else if (!nphase_r) begin
        high_nxt   = nib[3:0];
        nphase_nxt = 1'b1;
      end else begin
        nphase_nxt = 1'b0;
        if (byte_w == 8'h00) begin
          stopped_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
    end

    if (take) begin
      unique case (phase_r)
        PH_SEARCH: begin
          kcnt_nxt = kn;
          if (kn == KEY_LEN) begin
            phase_nxt = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (is_space) begin
            phase_nxt = PH_SPACE;
          end else if ((byte_w == 8'h2B) || (byte_w == 8'h2D)) begin
            neg_nxt   = (byte_w == 8'h2D);
            phase_nxt = PH_SIGNED;
          end else if (is_digit) begin
            acc_nxt   = acc_wide[31:0];
            digit_nxt = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_SIGNED, PH_DIGITS: begin
          if (is_digit) begin
            acc_nxt   = acc_wide[31:0];
            digit_nxt = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // Result as it stands after this beat.
    result.found = digit_nxt;
    if (!digit_nxt) begin
      result.value = NOT_FOUND;
    end else if (neg_nxt) begin
      result.value = 32'd0 - acc_nxt;
    end else begin
      result.value = acc_nxt[31] ? POS_MAX : acc_nxt;
    end

    // The last beat of a payload starts a fresh one.
    if (beat.last) begin
      nphase_nxt  = 1'b0;
      high_nxt    = 4'd0;
      stopped_nxt = 1'b0;
      kcnt_nxt    = 4'd0;
      phase_nxt   = PH_SEARCH;
      neg_nxt     = 1'b0;
      digit_nxt   = 1'b0;
      acc_nxt     = 32'd0;
    end
  end

  // State registers, updated once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nphase_r  <= 1'b0;
      high_r    <= 4'd0;
      stopped_r <= 1'b0;
      kcnt_r    <= 4'd0;
      phase_r   <= PH_SEARCH;
      neg_r     <= 1'b0;
      digit_r   <= 1'b0;
      acc_r     <= 32'd0;
    end else if (en) begin
      nphase_r  <= nphase_nxt;
      high_r    <= high_nxt;
      stopped_r <= stopped_nxt;
      kcnt_r    <= kcnt_nxt;
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      digit_r   <= digit_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

// ===== test/hex_payload_key_value_extractor_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the hex payload key/value extractor core.
module hex_payload_key_value_extractor_core_test;
  import hpkv_pkg::*;

  localparam int          CLK_HALF    = 4;
  localparam int          RAND_CHARS  = 1200;
  localparam int          TAIL_CYCLES = 20;
  localparam int          KEY_BYTES   = 8;
  localparam int          COLON_POS   = 7;
  localparam logic [63:0] KEY_STR     = "\"value\":";

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  hpkv_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hpkv_out_t out_data;

  hex_payload_key_value_extractor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Predicted parser state, one copy of what the block keeps per payload.
  logic        pr_low_next;
  logic [3:0]  pr_high;
  logic        pr_stopped;
  int unsigned pr_key_cnt;
  hpkv_phase_t pr_phase;
  logic        pr_neg;
  logic        pr_digit;
  logic [31:0] pr_mag;
  hpkv_out_t   pending_values[$];

  // Stimulus: characters of the payload under construction and all beats to send.
  logic [7:0]  frame_q[$];
  hpkv_in_t    beat_q[$];
  int          hex_case;
  int          payload_count;

  // Handshake bookkeeping of the drivers and the monitor; the taken counts pass between them.
  int          in_taken;
  int          in_taken_seen;
  int          in_wait;
  bit          in_quiet;
  int          out_taken;
  int          out_taken_seen;
  int          out_wait;
  bit          out_quiet;
  int          errors;

  // Value of an ASCII hex digit, or -1 for any other character.
  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic [7:0] key_at(input int unsigned k);
    return KEY_STR[63 - 8 * k -: 8];
  endfunction

  task automatic clear_parser();
    pr_low_next = 1'b0;
    pr_high     = 4'd0;
    pr_stopped  = 1'b0;
    pr_key_cnt  = 0;
    pr_phase    = PH_SEARCH;
    pr_neg      = 1'b0;
    pr_digit    = 1'b0;
    pr_mag      = 32'd0;
  endtask

  // Accumulate one decimal digit; the magnitude saturates at 2^31.
  task automatic push_digit(input logic [7:0] b);
    logic [35:0] grown;
    logic [3:0]  d;
    d     = b[3:0];
    grown = pr_mag * 36'd10 + d;
    if (grown > MAG_LIMIT) grown = MAG_LIMIT;
    pr_mag   = grown[31:0];
    pr_digit = 1'b1;
  endtask

  // Advance the key search or the number parse by one decoded byte.
  task automatic feed_byte(input logic [7:0] b);
    logic is_num;
    is_num = (b >= "0" && b <= "9");
    case (pr_phase)
      PH_SEARCH: begin
        // Only the colon position falls back to a matched opening quote.
        while (pr_key_cnt > 0 && b != key_at(pr_key_cnt))
          pr_key_cnt = (pr_key_cnt == COLON_POS) ? 1 : 0;
        if (b == key_at(pr_key_cnt)) pr_key_cnt++;
        if (pr_key_cnt == KEY_BYTES) pr_phase = PH_SPACE;
      end
      PH_SPACE: begin
        if (!(b == " " || (b >= 8'h09 && b <= 8'h0D))) begin
          if (b == "+" || b == "-") begin
            pr_neg   = (b == "-");
            pr_phase = PH_SIGNED;
          end else if (is_num) begin
            push_digit(b);
            pr_phase = PH_DIGITS;
          end else begin
            pr_phase = PH_DONE;
          end
        end
      end
      PH_SIGNED, PH_DIGITS: begin
        if (is_num) begin
          push_digit(b);
          pr_phase = PH_DIGITS;
        end else begin
          pr_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // Predict the effect of one accepted beat; a last beat yields one result.
  task automatic extract_char(input hpkv_in_t beat);
    int         nib;
    logic [7:0] b;
    hpkv_out_t  res;
    if (!pr_stopped) begin
      nib = hex_value(beat.hex_char);
      if (nib < 0) begin
        pr_stopped = 1'b1;
      end else if (!pr_low_next) begin
        pr_high     = nib[3:0];
        pr_low_next = 1'b1;
      end else begin
        b           = {pr_high, nib[3:0]};
        pr_low_next = 1'b0;
        if (b == 8'h00) pr_stopped = 1'b1;
        else feed_byte(b);
      end
    end
    if (beat.last) begin
      if (!pr_digit) res.value = NOT_FOUND;
      else if (pr_neg) res.value = 32'd0 - pr_mag;
      else res.value = (pr_mag > POS_MAX) ? POS_MAX : pr_mag;
      res.found = pr_digit;
      pending_values.push_back(res);
      clear_parser();
    end
  endtask

  // Hex digit for a nibble in the case style of the current payload.
  function automatic logic [7:0] hex_char_of(input logic [3:0] n);
    bit upper;
    upper = (hex_case == 2) ? bit'($urandom_range(0, 1)) : (hex_case == 1);
    if (n < 10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_value(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Nonzero filler byte, biased toward the characters of the key.
  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 9))
      0, 1, 2: return key_at($urandom_range(0, KEY_BYTES - 1));
      3:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return " ";
      default: return 8'($urandom_range(8'h09, 8'h0D));
    endcase
  endfunction

  task automatic add_raw(input logic [7:0] c);
    frame_q.push_back(c);
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_q.push_back(hex_char_of(b[7:4]));
    frame_q.push_back(hex_char_of(b[3:0]));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Turn the payload under construction into beats, last flag on the final one.
  task automatic close_frame();
    hpkv_in_t beat;
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < frame_q.size(); i++) begin
      beat.hex_char = frame_q[i];
      beat.last     = (i == frame_q.size() - 1);
      beat_q.push_back(beat);
    end
    frame_q.delete();
    payload_count++;
  endtask

  // Random text, an optional partial key, the key and some whitespace.
  task automatic fill_key_and_spaces();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) add_byte(pick_filler());
    case ($urandom_range(0, 5))
      0:       add_text("\"val");
      1:       add_text("\"value\"");
      2:       add_text("\"\"");
      default: ;
    endcase
    add_text("\"value\":");
    repeat ($urandom_range(0, 3)) add_byte(pick_space());
  endtask

  // Optional sign, mostly short digit runs, now and then a long one that may saturate; then filler.
  task automatic fill_number();
    int n;
    case ($urandom_range(0, 3))
      0:       add_byte("-");
      1:       add_byte("+");
      default: ;
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
    repeat (n) add_byte(8'(8'h30 + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 4)) add_byte(pick_filler());
  endtask

  task automatic fill_no_digit();
    case ($urandom_range(0, 3))
      0:       ;
      1:       add_byte($urandom_range(0, 1) ? "-" : "+");
      2: begin
        add_byte("-");
        add_byte("x");
      end
      default: add_byte("q");
    endcase
  endtask

  // Break a well-formed payload: bad hex digit, zero byte or early end.
  task automatic corrupt_frame();
    int pos;
    int keep;
    case ($urandom_range(0, 2))
      0: begin
        pos          = $urandom_range(0, frame_q.size() - 1);
        frame_q[pos] = pick_bad_char();
      end
      1: begin
        pos              = 2 * $urandom_range(0, frame_q.size() / 2 - 1);
        frame_q[pos]     = "0";
        frame_q[pos + 1] = "0";
      end
      default: begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
    endcase
  endtask

  // Free-running clock.
  initial begin : clock_gen
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Input driver: presents queued beats at the falling edge with random gaps.
  always @(negedge clk) begin : drive_in
    logic     nxt_valid;
    hpkv_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n) begin
      if (in_valid && in_taken != in_taken_seen) begin
        in_taken_seen = in_taken;
        nxt_valid     = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (beat_q.size() > 0) begin
          nxt_data  = beat_q.pop_front();
          nxt_valid = 1'b1;
          if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
          in_wait = in_quiet ? 0 : $urandom_range(0, 14);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Result stall: each result is held back for a freshly drawn number of cycles.
  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (out_taken != out_taken_seen) begin
        out_taken_seen = out_taken;
        if ($urandom_range(0, 63) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 14);
      end
      out_stall <= (out_wait > 0);
      if (out_wait > 0 && out_valid) out_wait--;
    end
  end

  // Monitor: predict on each accepted input beat, check each accepted result beat.
  always @(posedge clk) begin : watch
    hpkv_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        extract_char(in_data);
        in_taken++;
      end
      if (out_valid && !out_stall) begin
        out_taken++;
        if (pending_values.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d found %0b",
                   $time, $signed(out_data.value), out_data.found);
          errors++;
        end else begin
          want = pending_values.pop_front();
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d actual %0d",
                     $time, $signed(want.value), $signed(out_data.value));
            errors++;
          end
          if (out_data.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b actual %0b",
                     $time, want.found, out_data.found);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : main
    int base;
    int roll;
    clear_parser();

    // Directed payloads: plain number, whitespace and signs.
    hex_case = 0;
    add_text("\"value\":123");
    close_frame();
    hex_case = 1;
    add_text("x\"value\": \t");
    add_byte(8'h0B);
    add_byte(8'h0C);
    add_byte(8'h0D);
    add_text("-45");
    close_frame();
    hex_case = 2;
    add_text("\"value\":+7");
    close_frame();
    // Sign without digit and no digit at all.
    add_text("\"value\":-");
    close_frame();
    add_text("\"value\":x5");
    close_frame();
    // Fallback inside the key and at the colon position.
    add_text("\"valu\"value\":8");
    close_frame();
    add_text("\"value\"\"value\":5");
    close_frame();
    // Saturation at both ends and a found value of minus one.
    add_text("\"value\":2147483648");
    close_frame();
    add_text("\"value\":-2147483648");
    close_frame();
    add_text("\"value\":-99999999999");
    close_frame();
    add_text("\"value\":2147483647");
    close_frame();
    add_text("\"value\":-1");
    close_frame();
    // Invalid hex digit, zero byte, odd trailing character, end of number.
    add_text("\"val");
    add_raw("g");
    add_text("ue\":3");
    close_frame();
    add_text("\"value\":12");
    add_byte(8'h00);
    add_text("3");
    close_frame();
    add_text("\"value\":42");
    add_raw("7");
    close_frame();
    add_text("\"value\":12a34");
    close_frame();
    // Field extremes and a payload without the key.
    add_raw(8'h00);
    close_frame();
    add_byte(8'hFF);
    add_raw(8'hFF);
    close_frame();
    add_text("abc");
    close_frame();

    // Random part: mostly well-formed payloads, the rest broken or noise.
    base = beat_q.size();
    while (beat_q.size() - base < RAND_CHARS) begin
      hex_case = $urandom_range(0, 2);
      roll     = $urandom_range(0, 9);
      if (roll <= 5) begin
        fill_key_and_spaces();
        fill_number();
        if ($urandom_range(0, 5) == 0) add_raw(hex_char_of(4'($urandom_range(0, 15))));
      end else if (roll <= 7) begin
        fill_key_and_spaces();
        fill_number();
        corrupt_frame();
      end else if (roll == 8) begin
        fill_key_and_spaces();
        fill_no_digit();
      end else begin
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 1)) add_raw(8'($urandom_range(0, 255)));
          else add_byte(8'($urandom_range(0, 255)));
        end
      end
      close_frame();
    end
    base = beat_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() > 0 || in_valid || pending_values.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d payloads in %0d character beats with random gaps and stalls.",
             payload_count, base);
    $display("Checked %0d results, %0d mismatches.", out_taken, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hpkv_pkg.sv
rtl/hpkv_parser.sv
rtl/hex_payload_key_value_extractor_core.sv
test/hex_payload_key_value_extractor_core_test.sv
